FILE: rtl/core/sle_pkg.sv
// Shared constants, codes and the cell command type of the list engine.
package sle_pkg;

  // list capacity and derived widths
  localparam int DEPTH  = 64;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 7;
  localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int STAT_W = 3;

  // request codes
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd0;
  localparam logic [FUNC_W-1:0] FN_LOCATE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PRIOR  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_NEXT   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_PRIOR  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_NEXT   = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

  // cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_ROT  = 2'd1;
  localparam logic [1:0] CELL_INS  = 2'd2;
  localparam logic [1:0] CELL_DEL  = 2'd3;

  // command broadcast to every cell
  typedef struct packed {
    logic [1:0]        op;
    logic [CMP_W-1:0]  pos_m1;
    logic [DATA_W-1:0] val;
  } sle_cmd_t;

endpackage

FILE: rtl/core/sle_cell.sv
// One list cell: holds one element and moves it to or from its neighbours.
module sle_cell
  import sle_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  cell_idx,
  input  sle_cmd_t          cmd,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CMP_W-1:0]  idx_x;

  assign idx_x = CMP_W'(cell_idx);

  // pick the next element: rotate and delete pull from the right, insert from the left or takes the new value
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_ROT:  data_nxt = right_data;
      CELL_INS: begin
        if (idx_x == cmd.pos_m1) begin
          data_nxt = cmd.val;
        end else if (idx_x > cmd.pos_m1) begin
          data_nxt = left_data;
        end
      end
      CELL_DEL: begin
        if (idx_x >= cmd.pos_m1) begin
          data_nxt = right_data;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

FILE: rtl/core/sle_ctrl.sv
// Request decode, length count, head-cell scan and result register.
module sle_ctrl
  import sle_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     busy,
  input  logic [DATA_W-1:0]        head_data,
  output sle_cmd_t                 cell_cmd,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [POS_W-1:0]         out_result_position,
  output logic [STAT_W-1:0]        out_status,
  output logic [POS_W-1:0]         out_list_count,
  output logic                     out_is_empty
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  logic [0:0]        state_r;
  logic [LEN_W-1:0]  len_r;
  logic [FUNC_W-1:0] func_r;
  logic [CMP_W-1:0]  pos_m1_r;
  logic [DATA_W-1:0] val_r;
  logic [IDX_W-1:0]  t_r;
  logic              found_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] resv_r;
  logic [DATA_W-1:0] prev_r;

  logic              strobe_r;
  logic [DATA_W-1:0] rv_r;
  logic [POS_W-1:0]  rp_r;
  logic [STAT_W-1:0] st_r;
  logic [POS_W-1:0]  cnt_r;
  logic              empty_r;

  logic              accept;
  logic [CMP_W-1:0]  posx;
  logic [CMP_W-1:0]  lenx;
  logic              pos_in_list;
  logic              ins_pos_ok;
  logic              full;
  logic              go_scan;
  logic [STAT_W-1:0] imm_status;
  logic [LEN_W-1:0]  len_nxt;
  logic [1:0]        imm_op;

  logic [CMP_W-1:0]  tx;
  logic              in_list;
  logic              match_now;
  logic [CMP_W-1:0]  idx_p1;
  logic              found_nxt;
  logic [IDX_W-1:0]  idx_nxt;
  logic [DATA_W-1:0] resv_nxt;
  logic [CMP_W-1:0]  fin_idx_p1;
  logic              scan_last;
  logic [DATA_W-1:0] fin_value;
  logic [POS_W-1:0]  fin_position;
  logic [STAT_W-1:0] fin_status;

  assign accept      = start && (state_r == S_IDLE);
  assign busy        = (state_r == S_SCAN);
  assign posx        = CMP_W'(in_position);
  assign lenx        = CMP_W'(len_r);
  assign pos_in_list = (posx != '0) && (posx <= lenx);
  assign ins_pos_ok  = (posx != '0) && (posx <= lenx + CMP_W'(1));
  assign full        = (len_r == LEN_W'(DEPTH));

  // decode a fresh request: finish at once or go scan the ring
  always_comb begin
    go_scan    = 1'b0;
    imm_status = ST_OK;
    len_nxt    = len_r;
    imm_op     = CELL_HOLD;
    unique case (in_func)
      FN_GET: begin
        if (pos_in_list) go_scan = 1'b1;
        else imm_status = ST_BAD_POS;
      end
      FN_LOCATE, FN_PRIOR, FN_NEXT: begin
        if (len_r == '0) imm_status = ST_NOT_FOUND;
        else go_scan = 1'b1;
      end
      FN_INSERT: begin
        if (full) begin
          imm_status = ST_FULL;
        end else if (!ins_pos_ok) begin
          imm_status = ST_BAD_POS;
        end else begin
          imm_op  = CELL_INS;
          len_nxt = len_r + LEN_W'(1);
        end
      end
      FN_DELETE: begin
        if (!pos_in_list) begin
          imm_status = ST_BAD_POS;
        end else begin
          imm_op  = CELL_DEL;
          len_nxt = len_r - LEN_W'(1);
        end
      end
      default: ;
    endcase
  end

  // drive the cell row: rotate while scanning, shift on an accepted edit
  always_comb begin
    cell_cmd.pos_m1 = posx - CMP_W'(1);
    cell_cmd.val    = in_value;
    if (state_r == S_SCAN) begin
      cell_cmd.op = CELL_ROT;
    end else if (accept) begin
      cell_cmd.op = imm_op;
    end else begin
      cell_cmd.op = CELL_HOLD;
    end
  end

  // one scan step: the head cell holds element t_r
  assign tx        = CMP_W'(t_r);
  assign in_list   = (tx < lenx);
  assign match_now = in_list && !found_r && (head_data == val_r);
  assign idx_p1    = CMP_W'(idx_r) + CMP_W'(1);
  assign found_nxt = found_r || match_now;
  assign idx_nxt   = match_now ? t_r : idx_r;
  assign scan_last = (t_r == IDX_W'(DEPTH - 1));

  always_comb begin
    resv_nxt = resv_r;
    unique case (func_r)
      FN_GET: begin
        if (tx == pos_m1_r) resv_nxt = head_data;
      end
      FN_PRIOR: begin
        if (match_now && (t_r != '0)) resv_nxt = prev_r;
      end
      FN_NEXT: begin
        if (found_r && in_list && (tx == idx_p1)) resv_nxt = head_data;
      end
      default: ;
    endcase
  end

  // result of a finished scan
  assign fin_idx_p1 = CMP_W'(idx_nxt) + CMP_W'(1);

  always_comb begin
    fin_value    = '0;
    fin_position = '0;
    fin_status   = ST_OK;
    unique case (func_r)
      FN_GET: fin_value = resv_nxt;
      FN_LOCATE: begin
        if (found_nxt) fin_position = POS_W'(fin_idx_p1);
        else fin_status = ST_NOT_FOUND;
      end
      FN_PRIOR: begin
        if (!found_nxt) fin_status = ST_NOT_FOUND;
        else if (idx_nxt == '0) fin_status = ST_NO_PRIOR;
        else fin_value = resv_nxt;
      end
      FN_NEXT: begin
        if (!found_nxt) fin_status = ST_NOT_FOUND;
        else if (fin_idx_p1 == lenx) fin_status = ST_NO_NEXT;
        else fin_value = resv_nxt;
      end
      default: ;
    endcase
  end

  // sequence requests and hold the result beat for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      len_r    <= '0;
      strobe_r <= 1'b0;
      t_r      <= '0;
      found_r  <= 1'b0;
      idx_r    <= '0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            func_r   <= in_func;
            pos_m1_r <= posx - CMP_W'(1);
            val_r    <= in_value;
            t_r      <= '0;
            found_r  <= 1'b0;
            idx_r    <= '0;
            resv_r   <= '0;
            if (go_scan) begin
              state_r <= S_SCAN;
            end else begin
              len_r    <= len_nxt;
              rv_r     <= '0;
              rp_r     <= '0;
              st_r     <= imm_status;
              cnt_r    <= POS_W'(len_nxt);
              empty_r  <= (len_nxt == '0);
              strobe_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          t_r     <= t_r + IDX_W'(1);
          found_r <= found_nxt;
          idx_r   <= idx_nxt;
          resv_r  <= resv_nxt;
          prev_r  <= head_data;
          if (scan_last) begin
            state_r  <= S_IDLE;
            rv_r     <= fin_value;
            rp_r     <= fin_position;
            st_r     <= fin_status;
            cnt_r    <= POS_W'(len_r);
            empty_r  <= (len_r == '0);
            strobe_r <= 1'b1;
          end
        end
      endcase
    end
  end

  assign out_strobe          = strobe_r;
  assign out_result_value    = rv_r;
  assign out_result_position = rp_r;
  assign out_status          = st_r;
  assign out_list_count      = cnt_r;
  assign out_is_empty        = empty_r;

endmodule

FILE: rtl/core/sequential_list_engine.sv
// Top level of the list engine: a ring of element cells and its controller.
//
//  channel  | ports                                            | handshake
//  ---------+--------------------------------------------------+------------------------
//  request  | in_func, in_position, in_value                   | start high, busy low
//  result   | out_result_value, out_result_position,           | out_strobe, one cycle
//           | out_status, out_list_count, out_is_empty         |
//
//  Insert, delete, failed and ignored requests take one cycle: the result beat
//  follows the accepting edge, and the next request may be taken in that cycle.
//  Get, locate, prior and next rotate the cell ring once round (busy high) while
//  the head cell is compared; the result beat follows the last rotation step.
//  Synchronous active-low reset empties the list; cell contents are left as they are.
//  The receiver cannot stall: each result beat is shown for exactly one cycle.
module sequential_list_engine
  import sle_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        in_func,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic [POS_W-1:0]         out_result_position,
  output logic [STAT_W-1:0]        out_status,
  output logic [POS_W-1:0]         out_list_count,
  output logic                     out_is_empty
);

  sle_cmd_t          cell_cmd;
  logic [DATA_W-1:0] cell_q [DEPTH];

  // controller
  sle_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .in_func             (in_func),
    .in_position         (in_position),
    .in_value            (in_value),
    .busy                (busy),
    .head_data           (cell_q[0]),
    .cell_cmd            (cell_cmd),
    .out_strobe          (out_strobe),
    .out_result_value    (out_result_value),
    .out_result_position (out_result_position),
    .out_status          (out_status),
    .out_list_count      (out_list_count),
    .out_is_empty        (out_is_empty)
  );

  // ring of cells: each sees both neighbours, the ends wrap round
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sle_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(i)),
      .cmd        (cell_cmd),
      .left_data  (cell_q[(i + DEPTH - 1) % DEPTH]),
      .right_data (cell_q[(i + 1) % DEPTH]),
      .data       (cell_q[i])
    );
  end

endmodule

FILE: tb/sequential_list_engine_test.sv
// Self-checking testbench for the list engine: request driver, shadow list and result checker.
`timescale 1ns / 1ps

module sequential_list_engine_test;
  import sle_pkg::*;

  localparam int N_ITEMS    = 1400;
  localparam int IDLE_LIMIT = 4000;

  // request codes the engine ignores
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         count;
    logic                     empty;
  } list_reply_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [FUNC_W-1:0]        in_func = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_result_value;
  logic [POS_W-1:0]         out_result_position;
  logic [STAT_W-1:0]        out_status;
  logic [POS_W-1:0]         out_list_count;
  logic                     out_is_empty;

  // requests waiting to be driven, replies waiting to come back
  list_req_t   pending[$];
  list_reply_t reply_q[$];

  // shadow copy of the list
  logic signed [DATA_W-1:0] shadow_list[DEPTH];
  int                       shadow_len = 0;

  logic signed [DATA_W-1:0] value_pool[16];
  int gap_left = 0;
  int burst_left = 0;
  int n_taken = 0;
  int n_checked = 0;
  int n_errors = 0;
  int peak_len = 0;
  int idle_cycles = 0;
  int op_seen[8];
  int status_seen[8];

  sequential_list_engine DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_func             (in_func),
    .in_position         (in_position),
    .in_value            (in_value),
    .out_strobe          (out_strobe),
    .out_result_value    (out_result_value),
    .out_result_position (out_result_position),
    .out_status          (out_status),
    .out_list_count      (out_list_count),
    .out_is_empty        (out_is_empty)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one request to the shadow list and return the reply it should give.
  function automatic list_reply_t list_apply(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                                             logic signed [DATA_W-1:0] v);
    list_reply_t r;
    int          pi;
    int          hit;
    int          k;
    r   = '0;
    pi  = int'(p);
    hit = shadow_len;
    // first match wins, so scan from the back
    for (k = shadow_len - 1; k >= 0; k--) begin
      if (shadow_list[k] == v) hit = k;
    end
    r.status = ST_OK;
    case (f)
      FN_GET: begin
        if (pi >= 1 && pi <= shadow_len) r.value = shadow_list[pi-1];
        else r.status = ST_BAD_POS;
      end
      FN_LOCATE: begin
        if (hit < shadow_len) r.position = POS_W'(hit + 1);
        else r.status = ST_NOT_FOUND;
      end
      FN_PRIOR: begin
        if (hit >= shadow_len) r.status = ST_NOT_FOUND;
        else if (hit == 0) r.status = ST_NO_PRIOR;
        else r.value = shadow_list[hit-1];
      end
      FN_NEXT: begin
        if (hit >= shadow_len) r.status = ST_NOT_FOUND;
        else if (hit + 1 == shadow_len) r.status = ST_NO_NEXT;
        else r.value = shadow_list[hit+1];
      end
      FN_INSERT: begin
        if (shadow_len >= DEPTH) r.status = ST_FULL;
        else if (pi < 1 || pi > shadow_len + 1) r.status = ST_BAD_POS;
        else begin
          // shift the tail up and drop the new word in
          for (k = shadow_len; k >= pi; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[pi-1] = v;
          shadow_len++;
        end
      end
      FN_DELETE: begin
        if (pi < 1 || pi > shadow_len) r.status = ST_BAD_POS;
        else begin
          for (k = pi; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
          shadow_len--;
        end
      end
      default: ;
    endcase
    r.count = POS_W'(shadow_len);
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a burst with none.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pool_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Position in 1..lim (1 when lim is below 1), weighted towards both ends.
  function automatic logic [POS_W-1:0] pick_pos(int lim);
    int r;
    if (lim < 1) return POS_W'(1);
    r = $urandom_range(0, 3);
    if (r == 0) return POS_W'(1);
    if (r == 1) return POS_W'(lim);
    return POS_W'($urandom_range(1, lim));
  endfunction

  // Drive requests: retire the accepted beat, then load the next after its gap.
  always @(posedge clk) begin : drive
    list_req_t nxt;
    logic      start_nxt;
    if (!rst_n) begin
      start       <= 1'b0;
      in_func     <= '0;
      in_position <= '0;
      in_value    <= '0;
    end else begin
      start_nxt = start;
      if (start && !busy) begin
        reply_q.push_back(list_apply(in_func, in_position, in_value));
        op_seen[in_func]++;
        n_taken++;
        if (shadow_len > peak_len) peak_len = shadow_len;
        start_nxt = 1'b0;
      end
      if (!start_nxt) begin
        if (gap_left > 0) gap_left--;
        else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          in_func     <= nxt.func;
          in_position <= nxt.pos;
          in_value    <= nxt.val;
          start_nxt   = 1'b1;
          gap_left    = pick_gap();
        end
      end
      start <= start_nxt;
    end
  end

  task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  // Check each result beat against the oldest outstanding reply.
  always @(posedge clk) begin : check
    list_reply_t want;
    if (rst_n && out_strobe) begin
      if (reply_q.size() == 0) begin
        flag_mismatch("unexpected result beat", DATA_W'(out_status), '0);
      end else begin
        want = reply_q.pop_front();
        n_checked++;
        status_seen[want.status]++;
        if (out_result_value !== want.value)
          flag_mismatch("result_value", out_result_value, want.value);
        if (out_result_position !== want.position)
          flag_mismatch("result_position", DATA_W'(out_result_position),
                        DATA_W'(want.position));
        if (out_status !== want.status)
          flag_mismatch("status", DATA_W'(out_status), DATA_W'(want.status));
        if (out_list_count !== want.count)
          flag_mismatch("list_count", DATA_W'(out_list_count), DATA_W'(want.count));
        if (out_is_empty !== want.empty)
          flag_mismatch("is_empty", DATA_W'(out_is_empty), DATA_W'(want.empty));
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
        $display("sequential_list_engine_test: done, errors");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // Build the request stream, release reset and wait for the last reply.
  initial begin : stimulus
    int  n_items;
    int  plan_len;
    bit  filling;
    int  r;
    list_req_t q;

    n_items  = 0;
    plan_len = 0;
    filling  = 1'b1;
    value_pool[0] = 32'sh7fffffff;
    value_pool[1] = 32'sh80000000;
    value_pool[2] = 0;
    value_pool[3] = -1;
    for (int i = 4; i < 16; i++) value_pool[i] = $urandom;

    // empty list: every read and delete misses
    pending.push_back('{FN_GET,    7'd1,   32'sd0});
    pending.push_back('{FN_DELETE, 7'd1,   32'sd0});
    pending.push_back('{FN_LOCATE, 7'd0,   32'sd5});
    pending.push_back('{FN_PRIOR,  7'd0,   32'sd5});
    pending.push_back('{FN_NEXT,   7'd0,   32'sd5});
    // insert bounds, then build 0, max, min
    pending.push_back('{FN_INSERT, 7'd0,   32'sd9});
    pending.push_back('{FN_INSERT, 7'd2,   32'sd9});
    pending.push_back('{FN_INSERT, 7'd1,   32'sh7fffffff});
    pending.push_back('{FN_INSERT, 7'd2,   32'sh80000000});
    pending.push_back('{FN_INSERT, 7'd1,   32'sd0});
    pending.push_back('{FN_GET,    7'd0,   32'sd0});
    pending.push_back('{FN_GET,    7'd3,   32'sd0});
    pending.push_back('{FN_GET,    7'd4,   32'sd0});
    pending.push_back('{FN_GET,    7'd127, 32'sd0});
    pending.push_back('{FN_LOCATE, 7'd0,   32'sh80000000});
    pending.push_back('{FN_PRIOR,  7'd0,   32'sd0});
    pending.push_back('{FN_NEXT,   7'd0,   32'sh80000000});
    pending.push_back('{FN_PRIOR,  7'd0,   32'sh80000000});
    pending.push_back('{FN_NEXT,   7'd0,   32'sd0});
    pending.push_back('{FN_SPARE_LO, 7'd1,  32'sd1});
    pending.push_back('{FN_SPARE_HI, 7'd64, -32'sd1});
    pending.push_back('{FN_DELETE, 7'd4,   32'sd0});
    pending.push_back('{FN_DELETE, 7'd2,   32'sd0});
    pending.push_back('{FN_DELETE, 7'd127, 32'sd0});
    pending.push_back('{FN_INSERT, 7'd64,  32'sd3});
    n_items  = 23;
    plan_len = 2;

    // random part: fill to full, drain to empty, with reads and noise mixed in
    while (n_items < N_ITEMS) begin
      r = $urandom_range(0, 99);
      q.val = pool_value();
      if (r < 8) begin
        q.func = FUNC_W'($urandom_range(0, 7));
        q.pos  = POS_W'($urandom_range(0, 127));
        q.val  = $urandom;
      end else if (filling && plan_len == DEPTH) begin
        q.func  = FN_INSERT;
        q.pos   = pick_pos(plan_len);
        filling = 1'b0;
      end else if (!filling && plan_len == 0) begin
        q.func  = FN_DELETE;
        q.pos   = POS_W'(1);
        filling = 1'b1;
      end else if (r < (filling ? 68 : 18)) begin
        q.func = FN_INSERT;
        q.pos  = pick_pos(plan_len + 1);
      end else if (r < 78) begin
        q.func = FN_DELETE;
        q.pos  = pick_pos(plan_len);
      end else begin
        q.func = FUNC_W'($urandom_range(FN_GET, FN_NEXT));
        q.pos  = pick_pos(plan_len);
      end
      if ($urandom_range(0, 99) == 0) filling = !filling;
      // track the length so that later positions stay mostly legal
      if (q.func == FN_INSERT && plan_len < DEPTH && q.pos >= 1 && q.pos <= plan_len + 1)
        plan_len++;
      else if (q.func == FN_DELETE && q.pos >= 1 && q.pos <= plan_len)
        plan_len--;
      if (q.func <= FN_DELETE) n_items++;
      pending.push_back(q);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || start || reply_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (reply_q.size() != 0)
      flag_mismatch("replies never returned", DATA_W'(reply_q.size()), '0);

    $display("covered %0d requests (get %0d, locate %0d, prior %0d, next %0d, insert %0d, "
             , n_taken, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("  delete %0d, unused %0d); %0d results checked, peak length %0d, full %0d",
             op_seen[5], op_seen[6] + op_seen[7], n_checked, peak_len, status_seen[ST_FULL]);
    if (n_errors == 0) begin
      $display("sequential_list_engine_test: done, clean");
    end else begin
      $display("sequential_list_engine_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: sequential_list_engine.f
rtl/core/sle_pkg.sv
rtl/core/sle_cell.sv
rtl/core/sle_ctrl.sv
rtl/core/sequential_list_engine.sv
tb/sequential_list_engine_test.sv
